### design/eefc_pkg.sv
package eefc_pkg;

    // Default build values for the top-level parameters
    localparam int WINDOW_DEF      = 10;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF   = 16;

    // Fixed datapath widths
    localparam int COEF_W    = 20;
    localparam int ST_W      = 40;
    localparam int ACC_W     = 64;
    localparam int NOUT_W    = 17;
    localparam int ENV_W     = 16;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [ST_W-1:0]   t_st;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    // Register map; the notch terms also use these codes as term numbers
    localparam t_cfg_idx REG_HP_ALPHA = 3'd0;
    localparam t_cfg_idx REG_NOTCH_B0 = 3'd1;
    localparam t_cfg_idx REG_NOTCH_B1 = 3'd2;
    localparam t_cfg_idx REG_NOTCH_B2 = 3'd3;
    localparam t_cfg_idx REG_NOTCH_A1 = 3'd4;
    localparam t_cfg_idx REG_NOTCH_A2 = 3'd5;

    localparam t_coef COEF_RST [NUM_REGS] = '{
        20'sd58220, 20'sd64352, -20'sd119665, 20'sd64352, -20'sd119665, 20'sd63167
    };

    // Saturation bounds of the notch integer output
    localparam logic signed [NOUT_W-1:0] NO_MAX = 17'sd65535;
    localparam logic signed [NOUT_W-1:0] NO_MIN = -17'sd65536;

    typedef struct packed {
        logic     we;
        t_cfg_idx idx;
        t_coef    data;
    } t_cfg_wr;

    // Filter result handed to the averager
    typedef struct packed {
        logic signed [NOUT_W-1:0] notch_output;
        logic [ENV_W-1:0]         rect;
    } t_env_req;

endpackage

### design/eefc_sample_if.sv
interface eefc_sample_if
    import eefc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

### design/eefc_result_if.sv
interface eefc_result_if
    import eefc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [NOUT_W-1:0] notch_output;
    logic [ENV_W-1:0]         envelope;

    modport source (output valid, output notch_output, output envelope, input ready);
    modport sink   (input valid, input notch_output, input envelope, output ready);
endinterface

### design/eefc_front.sv
module eefc_front
    import eefc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [SAMPLE_BITS-1:0]      i_sample,
    output logic                        o_ready,
    input  logic                        i_q_full,
    output logic                        o_push,
    output logic signed [SAMPLE_BITS:0] o_delta
);

    logic [SAMPLE_BITS-1:0] r_last;
    logic [SAMPLE_BITS-1:0] n_last;

    // Take a beat whenever the queue has room
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // High-pass input difference x - x_prev, in whole sample units
    assign o_delta = $signed({1'b0, i_sample}) - $signed({1'b0, r_last});

    always_comb begin
        n_last = r_last;
        if (o_push) begin
            n_last = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else begin
            r_last <= n_last;
        end
    end

endmodule

### design/eefc_queue.sv
module eefc_queue
    import eefc_pkg::*;
#(
    parameter int WIDTH = SAMPLE_BITS_DEF + 1,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and occupancy update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue occupancy above depth");

endmodule

### design/eefc_filter.sv
module eefc_filter
    import eefc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cfg_wr                     i_cfg,
    input  logic                        i_q_valid,
    input  logic signed [SAMPLE_BITS:0] i_q_delta,
    output logic                        o_q_pop,
    output logic                        o_req_valid,
    output t_env_req                    o_req,
    input  logic                        i_req_ready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_HOLD  = 3'd4;

    localparam int MUL_W  = COEF_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int HALF_W = ST_W / 2;

    localparam logic signed [ACC_W-1:0] ACC_ST_MAX =
        {{(ACC_W-ST_W+1){1'b0}}, {(ST_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_ST_MIN = ~ACC_ST_MAX;
    localparam logic [ST_W-1:0] MAG_POS_MAX = ST_W'(2**ENV_W - 1);
    localparam logic [ST_W-1:0] MAG_NEG_MAX = ST_W'(2**ENV_W);

    function automatic t_st sat_st(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = v;
        if (v > ACC_ST_MAX) begin
            c = ACC_ST_MAX;
        end else if (v < ACC_ST_MIN) begin
            c = ACC_ST_MIN;
        end
        return c[ST_W-1:0];
    endfunction

    logic [2:0]              r_state, n_state;
    t_cfg_idx                r_term, n_term;
    logic                    r_half, n_half;
    logic                    r_pvalid, n_pvalid;
    logic                    r_psub, n_psub;
    logic                    r_pshift, n_pshift;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    t_st                     r_hpin, n_hpin;
    t_st                     r_hp_y, n_hp_y;
    t_st                     r_x1, n_x1, r_x2, n_x2;
    t_st                     r_y1, n_y1, r_y2, n_y2;
    t_env_req                r_req, n_req;
    t_coef                   r_coef [NUM_REGS];

    t_st                     opnd;
    logic signed [MUL_W-1:0] m_a, m_b;
    logic signed [ACC_W-1:0] prod_ext, prod_sh, delta_ext, hp_sum, acc_sh;
    t_st                     fin_val;
    logic [ST_W-1:0]         y_abs, mag;
    logic signed [NOUT_W-1:0] no_val;
    logic [ENV_W-1:0]        rect_val;

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_coef[i] <= COEF_RST[i];
            end
        end else if (i_cfg.we && (i_cfg.idx < CFG_IDX_W'(NUM_REGS))) begin
            r_coef[i_cfg.idx] <= i_cfg.data;
        end
    end

    // Operand for the current term
    always_comb begin
        case (r_term)
            REG_HP_ALPHA: opnd = r_hpin;
            REG_NOTCH_B0: opnd = r_hp_y;
            REG_NOTCH_B1: opnd = r_x1;
            REG_NOTCH_B2: opnd = r_x2;
            REG_NOTCH_A1: opnd = r_y1;
            REG_NOTCH_A2: opnd = r_y2;
            default:      opnd = '0;
        endcase
    end

    // 40-bit operand taken in two 20-bit halves: low half unsigned, high half signed
    assign m_a = {r_coef[r_term][COEF_W-1], r_coef[r_term]};
    assign m_b = r_half ? {opnd[ST_W-1], opnd[ST_W-1:HALF_W]}
                        : {1'b0, opnd[HALF_W-1:0]};

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
    end

    // Aligned partial product for the accumulator
    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign prod_sh  = r_pshift ? (prod_ext <<< HALF_W) : prod_ext;

    // High-pass pre-sum: y_prev + (x - x_prev) in fixed point
    assign delta_ext = {{(ACC_W-SAMPLE_BITS-1){i_q_delta[SAMPLE_BITS]}}, i_q_delta}
                       <<< FRAC_BITS;
    assign hp_sum    = {{(ACC_W-ST_W){r_hp_y[ST_W-1]}}, r_hp_y} + delta_ext;

    // Scale back and clamp the finished sum
    assign acc_sh  = r_acc >>> FRAC_BITS;
    assign fin_val = sat_st(acc_sh);

    // Integer part toward zero, then clamp for both result fields
    assign y_abs = fin_val[ST_W-1] ? (~fin_val + 1'b1) : fin_val;
    assign mag   = y_abs >> FRAC_BITS;

    always_comb begin
        if (!fin_val[ST_W-1]) begin
            no_val = (mag > MAG_POS_MAX) ? NO_MAX : $signed(mag[NOUT_W-1:0]);
        end else begin
            no_val = (mag > MAG_NEG_MAX) ? NO_MIN
                                         : $signed(NOUT_W'(0) - mag[NOUT_W-1:0]);
        end
        rect_val = (mag > MAG_POS_MAX) ? '1 : mag[ENV_W-1:0];
    end

    // Term sequencer
    always_comb begin
        n_state  = r_state;
        n_term   = r_term;
        n_half   = r_half;
        n_pvalid = 1'b0;
        n_psub   = r_psub;
        n_pshift = r_pshift;
        n_acc    = r_acc;
        n_hpin   = r_hpin;
        n_hp_y   = r_hp_y;
        n_x1     = r_x1;
        n_x2     = r_x2;
        n_y1     = r_y1;
        n_y2     = r_y2;
        n_req    = r_req;
        o_q_pop  = 1'b0;
        if (r_pvalid) begin
            n_acc = r_psub ? (r_acc - prod_sh) : (r_acc + prod_sh);
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_hpin  = sat_st(hp_sum);
                    n_term  = REG_HP_ALPHA;
                    n_half  = 1'b0;
                    n_acc   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_pvalid = 1'b1;
                n_psub   = (r_term == REG_NOTCH_A1) || (r_term == REG_NOTCH_A2);
                n_pshift = r_half;
                if (r_half) begin
                    n_half = 1'b0;
                    if ((r_term == REG_HP_ALPHA) || (r_term == REG_NOTCH_A2)) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_term = r_term + CFG_IDX_W'(1);
                    end
                end else begin
                    n_half = 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_acc = '0;
                if (r_term == REG_HP_ALPHA) begin
                    n_hp_y  = fin_val;
                    n_term  = REG_NOTCH_B0;
                    n_state = S_MUL;
                end else begin
                    n_x2  = r_x1;
                    n_x1  = r_hp_y;
                    n_y2  = r_y1;
                    n_y1  = fin_val;
                    n_req.notch_output = no_val;
                    n_req.rect         = rect_val;
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_req_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_term   <= REG_HP_ALPHA;
            r_half   <= 1'b0;
            r_pvalid <= 1'b0;
            r_psub   <= 1'b0;
            r_pshift <= 1'b0;
            r_acc    <= '0;
            r_hpin   <= '0;
            r_hp_y   <= '0;
            r_x1     <= '0;
            r_x2     <= '0;
            r_y1     <= '0;
            r_y2     <= '0;
            r_req    <= '0;
        end else begin
            r_state  <= n_state;
            r_term   <= n_term;
            r_half   <= n_half;
            r_pvalid <= n_pvalid;
            r_psub   <= n_psub;
            r_pshift <= n_pshift;
            r_acc    <= n_acc;
            r_hpin   <= n_hpin;
            r_hp_y   <= n_hp_y;
            r_x1     <= n_x1;
            r_x2     <= n_x2;
            r_y1     <= n_y1;
            r_y2     <= n_y2;
            r_req    <= n_req;
        end
    end

    assign o_req_valid = (r_state == S_HOLD);
    assign o_req       = r_req;

    a_fin_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> !r_pvalid)
        else $error("product still pending when accumulator is read");

endmodule

### design/eefc_avg.sv
module eefc_avg
    import eefc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    input  t_env_req                 i_req,
    output logic                     o_req_ready,
    output logic                     o_res_valid,
    output logic signed [NOUT_W-1:0] o_res_notch,
    output logic [ENV_W-1:0]         o_res_env,
    input  logic                     i_res_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = ENV_W + $clog2(WINDOW);
    localparam int CNT_W  = $clog2(ENV_W);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
    localparam logic [FILL_W-1:0] WIN_F     = FILL_W'(WINDOW);
    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(ENV_W - 1);

    logic [1:0]               r_state, n_state;
    logic [SLOT_W-1:0]        r_slot, n_slot;
    logic [FILL_W-1:0]        r_fill, n_fill;
    logic [SUM_W-1:0]         r_sum, n_sum;
    logic signed [NOUT_W-1:0] r_no, n_no;
    logic [ENV_W-1:0]         r_rect, n_rect;
    logic [ENV_W-1:0]         r_quo, n_quo;
    logic [FILL_W-1:0]        r_rem, n_rem;
    logic [FILL_W-1:0]        r_div, n_div;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_out_valid, n_out_valid;
    logic signed [NOUT_W-1:0] r_out_no, n_out_no;
    logic [ENV_W-1:0]         r_out_env, n_out_env;

    logic [ENV_W-1:0]         r_mem [WINDOW];
    logic [ENV_W-1:0]         r_rdata;

    logic [ENV_W-1:0]         old_val;
    logic [SUM_W-1:0]         sum_upd;
    logic [FILL_W-1:0]        fill_upd;
    logic [FILL_W:0]          rem_sh;
    logic                     rem_ge;

    // Window memory: read port follows the write slot, written in the update step
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_slot];
        if (r_state == S_UPD) begin
            r_mem[r_slot] <= r_rect;
        end
    end

    // Slots past the fill count have never been written since reset: they read as zero
    assign old_val  = (r_fill == WIN_F) ? r_rdata : '0;
    assign sum_upd  = r_sum - SUM_W'(old_val) + SUM_W'(r_rect);
    assign fill_upd = (r_fill == WIN_F) ? r_fill : r_fill + 1'b1;

    // One restoring division step
    assign rem_sh = {r_rem, r_quo[ENV_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_div});

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_no        = r_no;
        n_rect      = r_rect;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_div       = r_div;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out_no    = r_out_no;
        n_out_env   = r_out_env;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_no    = i_req.notch_output;
                    n_rect  = i_req.rect;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_sum  = sum_upd;
                n_fill = fill_upd;
                n_slot = (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
                n_div  = fill_upd;
                // Quotient fits 16 bits, so the sum's upper bits seed the remainder
                n_rem  = FILL_W'(sum_upd >> ENV_W);
                n_quo  = sum_upd[ENV_W-1:0];
                n_cnt  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = rem_ge ? FILL_W'(rem_sh - {1'b0, r_div}) : rem_sh[FILL_W-1:0];
                n_quo = {r_quo[ENV_W-2:0], rem_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out_valid = 1'b1;
                    n_out_no    = r_no;
                    n_out_env   = r_quo;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_no      <= n_no;
        r_rect    <= n_rect;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_out_no  <= n_out_no;
        r_out_env <= n_out_env;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res_notch = r_out_no;
    assign o_res_env   = r_out_env;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= WIN_F)
        else $error("fill count above window");

    a_slot_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != WIN_F) |-> (FILL_W'(r_slot) == r_fill))
        else $error("write slot out of step with fill count while filling");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

endmodule

### design/emg_envelope_filter_chain.sv
// EMG envelope filter chain.
// Input channel i_sample: one raw converter reading per beat (valid/ready).
// Output channel o_result: one beat per input beat, carrying the integer part
// of the notch output and the moving-average envelope, in input order.
// Coefficients are written through i_cfg_we / i_cfg_idx / i_cfg_wdata; the
// user must write them only while the block is idle (the block itself does
// not enforce this). Indexes beyond the notch a2 register are ignored.
// Structure: a front end takes samples and forms the high-pass input
// difference into a two-entry queue; the filter engine runs the high-pass
// and the notch on one shared 21x21 multiplier (twelve half products); the
// averager updates the window memory and runs a 16-step divider, which sets
// the sample rate, and the filter can work on the next sample meanwhile.
// A stall on o_result holds the result register; the averager and filter then
// fill up behind it and the queue stops taking samples once full.
// Reset (i_rst_n low, synchronous) restores the default coefficients and
// clears filter history, window sum, fill count and write slot: a new session.
module emg_envelope_filter_chain
    import eefc_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    eefc_sample_if.sink       i_sample,
    eefc_result_if.source     o_result,
    input  logic              i_cfg_we,
    input  t_cfg_idx          i_cfg_idx,
    input  logic [COEF_W-1:0] i_cfg_wdata
);

    logic                        q_full, q_valid, q_push, q_pop;
    logic signed [SAMPLE_BITS:0] f_delta;
    logic [SAMPLE_BITS:0]        q_data;
    t_cfg_wr                     cfg;
    logic                        req_valid, req_ready;
    t_env_req                    req;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = $signed(i_cfg_wdata);

    eefc_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_sample.valid),
        .i_sample (i_sample.sample),
        .o_ready  (i_sample.ready),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_delta  (f_delta)
    );

    eefc_queue #(
        .WIDTH (SAMPLE_BITS + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_delta),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_valid (q_valid)
    );

    eefc_filter #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_filter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_delta   ($signed(q_data)),
        .o_q_pop     (q_pop),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_ready (req_ready)
    );

    eefc_avg #(
        .WINDOW (WINDOW)
    ) u_avg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_ready (req_ready),
        .o_res_valid (o_result.valid),
        .o_res_notch (o_result.notch_output),
        .o_res_env   (o_result.envelope),
        .i_res_ready (o_result.ready)
    );

endmodule
